### sv/skvt_pkg.sv
// shared types for the sorted key and value table
// state and opcode encodings used by the sequencer
package skvt_pkg;

  localparam int unsigned CapacityDef  = 16;
  localparam int unsigned ValueBitsDef = 64;
  localparam int unsigned KeyBits      = 32;
  localparam int unsigned ValueWidth   = 64;
  localparam int unsigned CountBits    = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_EXEC,
    ST_SHRD,
    ST_SHWR,
    ST_RESP
  } state_e;

endpackage

### sv/skvt_mem.sv
// entry memory holding key and value pairs, one write and one registered read per cycle
// depends on nothing but its parameters
module skvt_mem #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned WIDTH    = 96
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [CAPACITY];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/skvt_seq.sv
// sequencer with the shared key comparator: linear search, then shift one entry per ST_SHRD and ST_SHWR pair
// depends on skvt_pkg; drives the ports of skvt_mem
module skvt_seq #(
  parameter int unsigned CAPACITY   = skvt_pkg::CapacityDef,
  parameter int unsigned VALUE_BITS = skvt_pkg::ValueBitsDef,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned EW = skvt_pkg::KeyBits + VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            opcode_i,
  input  logic signed [31:0]    key_i,
  input  logic [63:0]           value_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  found_o,
  output logic [63:0]           value_out_o,
  output logic                  status_o,
  output logic [4:0]            entry_count_o,
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_waddr_o,
  output logic [EW-1:0]         mem_wdata_o,
  output logic                  mem_re_o,
  output logic [AW-1:0]         mem_raddr_o,
  input  logic [EW-1:0]         mem_rdata_i
);

  skvt_pkg::state_e state_q, state_d;

  logic [1:0]            op_q, op_d;
  logic signed [31:0]    key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         pos_q, pos_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  hit_q, hit_d;
  logic                  status_q, status_d;
  logic [VALUE_BITS-1:0] rval_q, rval_d;

  logic                  ovalid_q, ovalid_d;
  logic                  ofound_q, ofound_d;
  logic [63:0]           ovalue_q, ovalue_d;
  logic                  ostatus_q, ostatus_d;
  logic [4:0]            ocount_q, ocount_d;

  logic signed [31:0]    rkey;
  logic [VALUE_BITS-1:0] rval;
  logic                  key_less;
  logic                  key_equal;
  logic                  full;
  logic                  in_beat;
  logic                  out_free;
  logic [CW-1:0]         idx_inc;
  logic [CW-1:0]         idx_dec;
  logic [63:0]           rval_ext;

  assign rkey      = mem_rdata_i[VALUE_BITS +: 32];
  assign rval      = mem_rdata_i[VALUE_BITS-1:0];
  assign key_less  = rkey < key_q;
  assign key_equal = rkey == key_q;
  assign full      = count_q == CW'(CAPACITY);
  assign in_beat   = in_valid_i && in_ready_o;
  assign out_free  = !ovalid_q || out_ready_i;
  assign idx_inc   = idx_q + CW'(1);
  assign idx_dec   = idx_q - CW'(1);

  always_comb begin
    rval_ext                   = '0;
    rval_ext[VALUE_BITS-1:0]   = rval_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skvt_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (opcode_i == skvt_pkg::OP_INSERT || opcode_i == skvt_pkg::OP_REMOVE ||
              opcode_i == skvt_pkg::OP_LOOKUP) begin
            state_d = skvt_pkg::ST_READ;
          end else begin
            state_d = skvt_pkg::ST_RESP;
          end
        end
      end
      skvt_pkg::ST_READ: begin
        state_d = (idx_q == count_q) ? skvt_pkg::ST_EXEC : skvt_pkg::ST_CMP;
      end
      skvt_pkg::ST_CMP: begin
        state_d = key_less ? skvt_pkg::ST_READ : skvt_pkg::ST_EXEC;
      end
      skvt_pkg::ST_EXEC: begin
        state_d = skvt_pkg::ST_RESP;
        if (op_q == skvt_pkg::OP_INSERT && !hit_q && !full) begin
          state_d = skvt_pkg::ST_SHRD;
        end else if (op_q == skvt_pkg::OP_REMOVE && hit_q) begin
          state_d = skvt_pkg::ST_SHRD;
        end
      end
      skvt_pkg::ST_SHRD: begin
        if (op_q == skvt_pkg::OP_INSERT) begin
          state_d = (idx_q == pos_q) ? skvt_pkg::ST_RESP : skvt_pkg::ST_SHWR;
        end else begin
          state_d = (idx_inc == count_q) ? skvt_pkg::ST_RESP : skvt_pkg::ST_SHWR;
        end
      end
      skvt_pkg::ST_SHWR: begin
        state_d = skvt_pkg::ST_SHRD;
      end
      skvt_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = skvt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = skvt_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    count_d     = count_q;
    hit_d       = hit_q;
    status_d    = status_q;
    rval_d      = rval_q;
    ovalid_d    = ovalid_q && !out_ready_i;
    ofound_d    = ofound_q;
    ovalue_d    = ovalue_q;
    ostatus_d   = ostatus_q;
    ocount_d    = ocount_q;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q[AW-1:0];
    mem_wdata_o = {key_q, val_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q[AW-1:0];
    unique case (state_q)
      skvt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_beat) begin
          op_d     = opcode_i;
          key_d    = key_i;
          val_d    = value_in_i[VALUE_BITS-1:0];
          idx_d    = '0;
          hit_d    = 1'b0;
          status_d = 1'b0;
          rval_d   = '0;
        end
      end
      skvt_pkg::ST_READ: begin
        if (idx_q == count_q) begin
          pos_d = idx_q;
          hit_d = 1'b0;
        end else begin
          mem_re_o = 1'b1;
        end
      end
      skvt_pkg::ST_CMP: begin
        if (key_less) begin
          idx_d = idx_inc;
        end else begin
          pos_d  = idx_q;
          hit_d  = key_equal;
          rval_d = rval;
        end
      end
      skvt_pkg::ST_EXEC: begin
        if (op_q == skvt_pkg::OP_INSERT) begin
          if (hit_q) begin
            mem_we_o = 1'b1;
          end else if (full) begin
            status_d = 1'b1;
          end else begin
            idx_d = count_q;
          end
        end else if (op_q == skvt_pkg::OP_REMOVE && hit_q) begin
          idx_d = pos_q;
        end
      end
      skvt_pkg::ST_SHRD: begin
        if (op_q == skvt_pkg::OP_INSERT) begin
          if (idx_q == pos_q) begin
            mem_we_o = 1'b1;
            count_d  = count_q + CW'(1);
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_dec[AW-1:0];
          end
        end else begin
          if (idx_inc == count_q) begin
            count_d = count_q - CW'(1);
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_inc[AW-1:0];
          end
        end
      end
      skvt_pkg::ST_SHWR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[AW-1:0];
        mem_wdata_o = mem_rdata_i;
        idx_d       = (op_q == skvt_pkg::OP_INSERT) ? idx_dec : idx_inc;
      end
      skvt_pkg::ST_RESP: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          ofound_d  = hit_q;
          ovalue_d  = (op_q == skvt_pkg::OP_LOOKUP && hit_q) ? rval_ext : '0;
          ostatus_d = status_q;
          ocount_d  = 5'(count_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= skvt_pkg::ST_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    val_q     <= val_d;
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    hit_q     <= hit_d;
    status_q  <= status_d;
    rval_q    <= rval_d;
    ofound_q  <= ofound_d;
    ovalue_q  <= ovalue_d;
    ostatus_q <= ostatus_d;
    ocount_q  <= ocount_d;
  end

  assign out_valid_o   = ovalid_q;
  assign found_o       = ofound_q;
  assign value_out_o   = ovalue_q;
  assign status_o      = ostatus_q;
  assign entry_count_o = ocount_q;

endmodule

### sv/sorted_key_value_table.sv
// the search compares entries in order and stops at slot p or after all n entries; the
// unused opcode goes straight to the result; a new key inserted into a non-full table
// moves p..n-1 up, a remove hit moves p+1..n-1 down; one memory port pair serves each step
// throughput: one beat at a time, the next is taken once the result register is loaded
// reset clears the entry count and the control state; the entry memory is not cleared
// top level of the sorted key and value table, depends on skvt_pkg, skvt_mem and skvt_seq
module sorted_key_value_table #(
  parameter int unsigned CAPACITY   = skvt_pkg::CapacityDef,
  parameter int unsigned VALUE_BITS = skvt_pkg::ValueBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] key_i,
  input  logic [63:0]        value_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [63:0]        value_out_o,
  output logic               status_o,
  output logic [4:0]         entry_count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned EW = skvt_pkg::KeyBits + VALUE_BITS;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  skvt_mem #(
    .CAPACITY (CAPACITY),
    .WIDTH    (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  skvt_seq #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .key_i         (key_i),
    .value_in_i    (value_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .value_out_o   (value_out_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  a_refused_not_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !found_o)
    else $error("refused insert reported as hit");

  a_value_needs_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (value_out_o != 64'd0) |-> found_o)
    else $error("value returned without hit");

  a_busy_after_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CAPACITY > 31) || (entry_count_o <= 5'(CAPACITY)))
    else $error("entry count above capacity");

endmodule
